// ===== rtl/lscf_pkg.sv =====
// shared types, codes and solve microprogram for the circle fit block
`default_nettype none

package lscf_pkg;

	// working width of the solve datapath; covers the largest radius numerator
	localparam int WIDE_W = 320;
	localparam int NREG = 19;
	localparam int PROG_LEN = 79;
	localparam int PC_W = $clog2(PROG_LEN);

	typedef enum logic [1:0] {
		OPER_APPEND = 2'd0,
		OPER_SOLVE  = 2'd1,
		OPER_CLEAR  = 2'd2,
		OPER_NONE   = 2'd3
	} oper_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_SINGULAR = 2'd1,
		STAT_OVERFLOW = 2'd2
	} stat_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic signed [15:0]  point_x;
		logic signed [15:0]  point_y;
	} item_t;

	typedef struct packed {
		stat_t               status;
		logic signed [31:0]  center_x;
		logic signed [31:0]  center_y;
		logic [31:0]         radius;
	} result_t;

	// solve register file slots
	typedef enum logic [4:0] {
		R_XX, R_XY, R_X, R_YY, R_Y, R_N, R_RX, R_RY, R_RR,
		R_D, R_DC0, R_DC1, R_DC2, R_ACC, R_P1, R_P2, R_P3, R_NUM, R_DEN
	} reg_t;

	typedef enum logic [3:0] {
		UOP_LOAD, UOP_MUL, UOP_ADD, UOP_SUB, UOP_SHL2,
		UOP_TSTD, UOP_CX, UOP_CY, UOP_RAD, UOP_END
	} uop_t;

	typedef struct packed {
		uop_t op;
		reg_t dst;
		reg_t a;
		reg_t b;
	} instr_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DRAIN, ST_FETCH, ST_EXEC, ST_MUL,
		ST_DIV, ST_SQRT, ST_WRITE, ST_EMIT
	} state_t;

	typedef struct packed {
		logic   append;
		logic   clear_sums;
		logic   clr_out;
		logic   rd;
		reg_t   ra;
		reg_t   rb;
		logic   go;
		logic   step;
		logic   finish;
		logic   sq_step;
		logic   rad_load;
		logic   wr;
		reg_t   wa;
		uop_t   op;
		logic   set_stat;
		stat_t  stat;
	} cmd_t;

	typedef struct packed {
		logic pipe_empty;
		logic overflow;
		logic a_zero;
		logic a_neg;
		logic mul_done;
		logic div_done;
		logic q_big;
		logic sq_done;
	} sts_t;

	// cramer solve: sums loaded, four 3x3 determinants, then centre and radius
	localparam instr_t PROG [PROG_LEN] = '{
		'{UOP_LOAD, R_XX, R_XX, R_XX},
		'{UOP_LOAD, R_XY, R_XX, R_XX},
		'{UOP_LOAD, R_X,  R_XX, R_XX},
		'{UOP_LOAD, R_YY, R_XX, R_XX},
		'{UOP_LOAD, R_Y,  R_XX, R_XX},
		'{UOP_LOAD, R_N,  R_XX, R_XX},
		'{UOP_LOAD, R_RX, R_XX, R_XX},
		'{UOP_LOAD, R_RY, R_XX, R_XX},
		'{UOP_LOAD, R_RR, R_XX, R_XX},
		// det of the moment matrix
		'{UOP_MUL, R_P1,  R_YY,  R_N},
		'{UOP_MUL, R_P2,  R_Y,   R_Y},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_ACC, R_XX,  R_P1},
		'{UOP_MUL, R_P1,  R_XY,  R_N},
		'{UOP_MUL, R_P2,  R_Y,   R_X},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_P1,  R_XY,  R_P1},
		'{UOP_SUB, R_ACC, R_ACC, R_P1},
		'{UOP_MUL, R_P1,  R_XY,  R_Y},
		'{UOP_MUL, R_P2,  R_YY,  R_X},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_P1,  R_X,   R_P1},
		'{UOP_ADD, R_D,   R_ACC, R_P1},
		'{UOP_TSTD, R_D,  R_D,   R_D},
		// first column replaced
		'{UOP_MUL, R_P1,  R_YY,  R_N},
		'{UOP_MUL, R_P2,  R_Y,   R_Y},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_ACC, R_RX,  R_P1},
		'{UOP_MUL, R_P1,  R_RY,  R_N},
		'{UOP_MUL, R_P2,  R_Y,   R_RR},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_P1,  R_XY,  R_P1},
		'{UOP_SUB, R_ACC, R_ACC, R_P1},
		'{UOP_MUL, R_P1,  R_RY,  R_Y},
		'{UOP_MUL, R_P2,  R_YY,  R_RR},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_P1,  R_X,   R_P1},
		'{UOP_ADD, R_DC0, R_ACC, R_P1},
		// second column replaced
		'{UOP_MUL, R_P1,  R_RY,  R_N},
		'{UOP_MUL, R_P2,  R_Y,   R_RR},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_ACC, R_XX,  R_P1},
		'{UOP_MUL, R_P1,  R_XY,  R_N},
		'{UOP_MUL, R_P2,  R_Y,   R_X},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_P1,  R_RX,  R_P1},
		'{UOP_SUB, R_ACC, R_ACC, R_P1},
		'{UOP_MUL, R_P1,  R_XY,  R_RR},
		'{UOP_MUL, R_P2,  R_RY,  R_X},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_P1,  R_X,   R_P1},
		'{UOP_ADD, R_DC1, R_ACC, R_P1},
		// third column replaced
		'{UOP_MUL, R_P1,  R_YY,  R_RR},
		'{UOP_MUL, R_P2,  R_RY,  R_Y},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_ACC, R_XX,  R_P1},
		'{UOP_MUL, R_P1,  R_XY,  R_RR},
		'{UOP_MUL, R_P2,  R_RY,  R_X},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_P1,  R_XY,  R_P1},
		'{UOP_SUB, R_ACC, R_ACC, R_P1},
		'{UOP_MUL, R_P1,  R_XY,  R_Y},
		'{UOP_MUL, R_P2,  R_YY,  R_X},
		'{UOP_SUB, R_P1,  R_P1,  R_P2},
		'{UOP_MUL, R_P1,  R_RX,  R_P1},
		'{UOP_ADD, R_DC2, R_ACC, R_P1},
		// centre, then radius numerator and denominator
		'{UOP_ADD,  R_P3,  R_D,   R_D},
		'{UOP_CX,   R_P3,  R_DC0, R_P3},
		'{UOP_CY,   R_P3,  R_DC1, R_P3},
		'{UOP_MUL,  R_P1,  R_DC2, R_D},
		'{UOP_SHL2, R_P1,  R_P1,  R_P1},
		'{UOP_MUL,  R_P2,  R_DC0, R_DC0},
		'{UOP_MUL,  R_NUM, R_DC1, R_DC1},
		'{UOP_ADD,  R_NUM, R_P2,  R_NUM},
		'{UOP_ADD,  R_NUM, R_P1,  R_NUM},
		'{UOP_MUL,  R_P1,  R_D,   R_D},
		'{UOP_SHL2, R_DEN, R_P1,  R_P1},
		'{UOP_RAD,  R_DEN, R_NUM, R_DEN},
		'{UOP_END,  R_XX,  R_XX,  R_XX}
	};

endpackage

`default_nettype wire

// ===== rtl/lscf_ctrl.sv =====
// controller: accepts transactions and sequences the solve microprogram
`default_nettype none

module lscf_ctrl
	import lscf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  oper,
	input  sts_t        sts,
	output logic        busy,
	output logic        done,
	output cmd_t        cmd
);

	state_t state_q, state_d;
	logic [PC_W-1:0] pc_q;
	logic pc_clr, pc_inc;
	instr_t ins;

	assign ins = PROG[pc_q];
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
		end else begin
			state_q <= state_d;
			if (pc_clr)
				pc_q <= '0;
			else if (pc_inc)
				pc_q <= pc_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_clr = 1'b0;
		pc_inc = 1'b0;
		cmd = '0;
		cmd.op = ins.op;
		cmd.wa = ins.dst;
		cmd.ra = ins.a;
		cmd.rb = ins.b;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (oper)
						OPER_APPEND: cmd.append = 1'b1;
						OPER_SOLVE: begin
							cmd.clr_out = 1'b1;
							pc_clr = 1'b1;
							state_d = ST_DRAIN;
						end
						OPER_CLEAR: cmd.clear_sums = 1'b1;
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					if (sts.overflow) begin
						cmd.set_stat = 1'b1;
						cmd.stat = STAT_OVERFLOW;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.rd = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.go = 1'b1;
				case (ins.op)
					UOP_MUL: state_d = ST_MUL;
					UOP_LOAD, UOP_ADD, UOP_SUB, UOP_SHL2: state_d = ST_WRITE;
					UOP_TSTD: begin
						if (sts.a_zero) begin
							cmd.set_stat = 1'b1;
							cmd.stat = STAT_SINGULAR;
							state_d = ST_EMIT;
						end else begin
							pc_inc = 1'b1;
							state_d = ST_FETCH;
						end
					end
					UOP_CX, UOP_CY: state_d = ST_DIV;
					UOP_RAD: begin
						if (sts.a_zero || sts.a_neg) begin
							pc_inc = 1'b1;
							state_d = ST_FETCH;
						end else begin
							state_d = ST_DIV;
						end
					end
					default: state_d = ST_EMIT;
				endcase
			end
			ST_MUL: begin
				if (sts.mul_done)
					state_d = ST_WRITE;
				else
					cmd.step = 1'b1;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.finish = 1'b1;
					if (ins.op == UOP_RAD && !sts.q_big) begin
						state_d = ST_SQRT;
					end else begin
						pc_inc = 1'b1;
						state_d = ST_FETCH;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_SQRT: begin
				if (sts.sq_done) begin
					cmd.rad_load = 1'b1;
					pc_inc = 1'b1;
					state_d = ST_FETCH;
				end else begin
					cmd.sq_step = 1'b1;
				end
			end
			ST_WRITE: begin
				cmd.wr = 1'b1;
				pc_inc = 1'b1;
				state_d = ST_FETCH;
			end
			ST_EMIT: begin
				cmd.clear_sums = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/lscf_dp.sv =====
// datapath: moment accumulators, serial multiplier, divider and square root
`default_nettype none

module lscf_dp
	import lscf_pkg::*;
#(
	parameter int MAX_POINTS    = 65536,
	parameter int FRACTION_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    item,
	input  cmd_t     cmd,
	output sts_t     sts,
	output result_t  result
);

	localparam int W = WIDE_W;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int ITER_W = $clog2(W + 1);

	// moment sums
	logic signed [47:0] sum_xx_q, sum_yy_q, sum_xy_q, sum_rr_q;
	logic signed [32:0] sum_x_q, sum_y_q;
	logic signed [63:0] sum_rx_q, sum_ry_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic               full;

	// append pipeline
	logic               v_s1, v_s2;
	logic signed [31:0] xx_s1, yy_s1, xy_s1, xx_s2, yy_s2, xy_s2;
	logic signed [15:0] x_s1, y_s1, x_s2, y_s2;
	logic signed [32:0] r_sum, r_s2;
	logic signed [48:0] rx_s2, ry_s2;

	// solve storage and units
	logic [W-1:0] rf [NREG];
	logic [W-1:0] rd_a_s1, rd_b_s1, res_q, ld_val, a_abs, b_abs;
	logic [W-1:0] ma_q, mb_q;
	logic [W-1:0] n_q, d_q, r_q, r_sh, r_dif;
	logic         r_ge, neg_q;
	logic [ITER_W-1:0] iter_q;
	logic [63:0]  sq_v_q, sq_res_q, sq_bit_q, sq_trial;
	logic         sq_ge;
	logic [31:0]  q_lo, sat;
	logic         q_hi_nz, is_div;

	stat_t              stat_q;
	logic signed [31:0] cx_q, cy_q;
	logic [31:0]        rad_q;

	assign full = (count_q >= CNT_W'(MAX_POINTS));
	assign r_sum = 33'(xx_s1) + 33'(yy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			sum_rr_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_rx_q <= '0;
			sum_ry_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			iter_q <= '0;
			stat_q <= STAT_OK;
		end else begin
			v_s1 <= cmd.append && !full;
			v_s2 <= v_s1 && !cmd.clear_sums;
			if (cmd.clear_sums) begin
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				sum_xy_q <= '0;
				sum_rr_q <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_rx_q <= '0;
				sum_ry_q <= '0;
				count_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (cmd.append) begin
					if (full)
						ovf_q <= 1'b1;
					else
						count_q <= count_q + 1'b1;
				end
				if (v_s2) begin
					sum_xx_q <= sum_xx_q + 48'(xx_s2);
					sum_yy_q <= sum_yy_q + 48'(yy_s2);
					sum_xy_q <= sum_xy_q + 48'(xy_s2);
					sum_rr_q <= sum_rr_q + 48'(r_s2);
					sum_x_q <= sum_x_q + 33'(x_s2);
					sum_y_q <= sum_y_q + 33'(y_s2);
					sum_rx_q <= sum_rx_q + 64'(rx_s2);
					sum_ry_q <= sum_ry_q + 64'(ry_s2);
				end
			end
			if (cmd.go && is_div)
				iter_q <= ITER_W'(W);
			else if (cmd.step && is_div && iter_q != '0)
				iter_q <= iter_q - 1'b1;
			if (cmd.set_stat)
				stat_q <= cmd.stat;
			else if (cmd.clr_out)
				stat_q <= STAT_OK;
		end
	end

	// append pipeline payload
	always_ff @(posedge clk) begin
		xx_s1 <= item.point_x * item.point_x;
		yy_s1 <= item.point_y * item.point_y;
		xy_s1 <= item.point_x * item.point_y;
		x_s1 <= item.point_x;
		y_s1 <= item.point_y;
		xx_s2 <= xx_s1;
		yy_s2 <= yy_s1;
		xy_s2 <= xy_s1;
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		r_s2 <= r_sum;
		rx_s2 <= r_sum * x_s1;
		ry_s2 <= r_sum * y_s1;
	end

	always_comb begin
		case (cmd.wa)
			R_XX: ld_val = W'(sum_xx_q);
			R_XY: ld_val = W'(sum_xy_q);
			R_X: ld_val = W'(sum_x_q);
			R_YY: ld_val = W'(sum_yy_q);
			R_Y: ld_val = W'(sum_y_q);
			R_N: ld_val = {{(W-CNT_W){1'b0}}, count_q};
			R_RX: ld_val = W'(sum_rx_q);
			R_RY: ld_val = W'(sum_ry_q);
			R_RR: ld_val = W'(sum_rr_q);
			default: ld_val = '0;
		endcase
	end

	assign is_div = (cmd.op == UOP_CX) || (cmd.op == UOP_CY) || (cmd.op == UOP_RAD);
	assign a_abs = rd_a_s1[W-1] ? (~rd_a_s1 + 1'b1) : rd_a_s1;
	assign b_abs = rd_b_s1[W-1] ? (~rd_b_s1 + 1'b1) : rd_b_s1;

	// restoring division, one quotient bit per step
	assign r_sh = {r_q[W-2:0], n_q[W-1]};
	assign r_ge = (r_sh >= d_q);
	assign r_dif = r_sh - d_q;

	// digit-by-digit root, two radicand bits per step
	assign sq_trial = sq_res_q + sq_bit_q;
	assign sq_ge = (sq_v_q >= sq_trial);

	// signed 32-bit saturation of the centre quotient
	assign q_lo = n_q[31:0];
	assign q_hi_nz = |n_q[W-1:32];
	always_comb begin
		if (neg_q) begin
			if (q_hi_nz || q_lo > 32'h8000_0000)
				sat = 32'h8000_0000;
			else
				sat = ~q_lo + 1'b1;
		end else begin
			if (q_hi_nz || q_lo[31])
				sat = 32'h7FFF_FFFF;
			else
				sat = q_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr)
			rf[cmd.wa] <= res_q;
		if (cmd.rd) begin
			rd_a_s1 <= rf[cmd.ra];
			rd_b_s1 <= rf[cmd.rb];
		end
		if (cmd.go) begin
			case (cmd.op)
				UOP_LOAD: res_q <= ld_val;
				UOP_ADD: res_q <= rd_a_s1 + rd_b_s1;
				UOP_SUB: res_q <= rd_a_s1 - rd_b_s1;
				UOP_SHL2: res_q <= rd_a_s1 << 2;
				UOP_MUL: begin
					res_q <= '0;
					ma_q <= rd_a_s1;
					mb_q <= rd_b_s1;
				end
				UOP_CX, UOP_CY: begin
					n_q <= a_abs << FRACTION_BITS;
					d_q <= b_abs;
					r_q <= '0;
					neg_q <= rd_a_s1[W-1] ^ rd_b_s1[W-1];
				end
				UOP_RAD: begin
					n_q <= rd_a_s1 << (2 * FRACTION_BITS);
					d_q <= rd_b_s1;
					r_q <= '0;
					neg_q <= 1'b0;
				end
				default: ;
			endcase
		end
		if (cmd.step) begin
			if (cmd.op == UOP_MUL) begin
				if (mb_q[0])
					res_q <= res_q + ma_q;
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end else if (is_div) begin
				r_q <= r_ge ? r_dif : r_sh;
				n_q <= {n_q[W-2:0], r_ge};
			end
		end
		if (cmd.finish) begin
			case (cmd.op)
				UOP_CX: cx_q <= sat;
				UOP_CY: cy_q <= sat;
				UOP_RAD: begin
					if (sts.q_big)
						rad_q <= '1;
					sq_v_q <= n_q[63:0];
					sq_res_q <= '0;
					sq_bit_q <= 64'h4000_0000_0000_0000;
				end
				default: ;
			endcase
		end
		if (cmd.sq_step) begin
			if (sq_ge) begin
				sq_v_q <= sq_v_q - sq_trial;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.rad_load)
			rad_q <= sq_res_q[31:0];
		if (cmd.clr_out) begin
			cx_q <= '0;
			cy_q <= '0;
			rad_q <= '0;
		end
	end

	always_comb begin
		sts.pipe_empty = !v_s1 && !v_s2;
		sts.overflow = ovf_q;
		sts.a_zero = (rd_a_s1 == '0);
		sts.a_neg = rd_a_s1[W-1];
		sts.mul_done = (mb_q == '0);
		sts.div_done = (iter_q == '0);
		sts.q_big = |n_q[W-1:64];
		sts.sq_done = (sq_bit_q == '0);
	end

	assign result = '{status: stat_q, center_x: cx_q, center_y: cy_q, radius: rad_q};

endmodule

`default_nettype wire

// ===== rtl/least_squares_circle_fit.sv =====
// top level of the algebraic least-squares circle fit
`default_nettype none

// Kasa circle fit over signed 16-bit points. A transaction is taken when start
// is high and busy is low. Append and clear transactions leave busy low, so
// points can stream in back to back; an append reaches the moment sums through
// a two-stage multiply pipeline. A solve raises busy, waits for that pipeline
// to drain, then runs a stored microprogram of about eighty steps over a
// 320-bit register file: the four Cramer determinants and the radius terms
// come from a shift-add multiplier that retires one multiplier bit per cycle
// (a product ends once the remaining multiplier bits are all zero, early for
// small positive operands), up to three restoring divisions and an integer
// square root. The serial multiplier sets the solve time. The fit appears on
// result with done high for exactly one cycle; the receiver cannot hold it off,
// so it must capture it then. The sums and the count are emptied, and busy
// drops, in the cycle after.
module least_squares_circle_fit
	import lscf_pkg::*;
#(
	parameter int MAX_POINTS    = 65536,
	parameter int FRACTION_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  item_t    item,
	output logic     busy,
	output logic     done,
	output result_t  result
);

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	lscf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.oper   (item.operation),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	lscf_dp #(
		.MAX_POINTS    (MAX_POINTS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	// the result strobe only comes out of a solve in progress
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without a solve in progress");

	// block is free again right after delivering a fit
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result delivery");

	// an accepted solve always occupies the block
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == OPER_SOLVE) |=> busy)
		else $error("solve accepted without going busy");

	// failed fits carry zero centre and radius
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |->
		(result.center_x == 0 && result.center_y == 0 && result.radius == 0))
		else $error("nonzero fit fields with failure status");

endmodule

`default_nettype wire
